[src/baro_pkg.sv]
// Shared types and constants of the barometric compensation block.
`timescale 1ns / 1ps

package baro_pkg;

   // Field widths of the request and response items.
   localparam int RAW_W    = 24;
   localparam int COEF_W   = 16;
   localparam int TEMP_W   = 19;
   localparam int PRES_W   = 32;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 56;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;

   // Number of register stages from request to response.
   localparam int NUM_STAGES = 8;

   // Temperature thresholds in hundredths of a degree.
   localparam int TEMP_REF_CENTI = 2000;
   localparam int TEMP_LOW_CENTI = 1500;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_COEF_SENS          = 3'd0,
      CSR_COEF_OFFSET        = 3'd1,
      CSR_COEF_SENS_TEMPCO   = 3'd2,
      CSR_COEF_OFFSET_TEMPCO = 3'd3,
      CSR_COEF_REF_TEMP      = 3'd4,
      CSR_COEF_TEMP_SLOPE    = 3'd5
   } csr_index_type;

endpackage

[src/baro_pressure_temp_compensation.sv]
// Top level: pipelined second-order temperature and pressure compensation.
`timescale 1ns / 1ps

// Each request carries one raw 24-bit pressure conversion and one raw 24-bit
// temperature conversion. The block applies the six factory calibration words
// held in the csr registers and returns the temperature in hundredths of a
// degree C and the pressure in pascal, with the second-order correction below
// 20.00 C and its extra term below -15.00 C. The datapath is an eight-stage
// pipeline: a request enters in every cycle while rsp_tready stays high, and
// its response leaves from the last stage. The depth is set by the chain of
// multiplications: the four products with dT, the two squares of the
// temperature deviation, and the 24 by 40 bit pressure product, which is
// split into two partial products and summed one stage later. When the
// response side stalls, each stage holds only while the stage after it is
// full, so empty slots fill up and nothing is lost or repeated. The
// calibration words must be written while no request is in flight.
module baro_pressure_temp_compensation (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel. req_tdata: raw_pressure [23:0], raw_temp [47:24].
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [baro_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // Response channel. rsp_tdata: temp_centi [18:0], pressure_pa [50:19],
   // zeros above.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [baro_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // Calibration word write port.
   input  logic                                csr_wen,
   input  logic [baro_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [baro_pkg::COEF_W-1:0]         csr_wdata
);
   import baro_pkg::*;

   // Calibration words C1 to C6.
   logic [COEF_W-1:0] coef_sens_ff;
   logic [COEF_W-1:0] coef_offset_ff;
   logic [COEF_W-1:0] coef_sens_tempco_ff;
   logic [COEF_W-1:0] coef_offset_tempco_ff;
   logic [COEF_W-1:0] coef_ref_temp_ff;
   logic [COEF_W-1:0] coef_temp_slope_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_sens_ff          <= '0;
         coef_offset_ff        <= '0;
         coef_sens_tempco_ff   <= '0;
         coef_offset_tempco_ff <= '0;
         coef_ref_temp_ff      <= '0;
         coef_temp_slope_ff    <= '0;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_addr))
            CSR_COEF_SENS:          coef_sens_ff          <= csr_wdata;
            CSR_COEF_OFFSET:        coef_offset_ff        <= csr_wdata;
            CSR_COEF_SENS_TEMPCO:   coef_sens_tempco_ff   <= csr_wdata;
            CSR_COEF_OFFSET_TEMPCO: coef_offset_tempco_ff <= csr_wdata;
            CSR_COEF_REF_TEMP:      coef_ref_temp_ff      <= csr_wdata;
            CSR_COEF_TEMP_SLOPE:    coef_temp_slope_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Stage valid bits and the load enables. A stage loads when it is empty or
   // when the stage after it moves on in the same cycle.
   logic [NUM_STAGES:1] vld_ff;
   logic [NUM_STAGES:1] en;

   always_comb begin
      en[NUM_STAGES] = !vld_ff[NUM_STAGES] || rsp_tready;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[1]) begin
            vld_ff[1] <= req_tvalid;
         end
         for (int k = 2; k <= NUM_STAGES; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign req_tready = en[1];
   assign rsp_tvalid = vld_ff[NUM_STAGES];

   // Stage 1: dT = D2 - C5 * 2^8, a 25-bit signed value.
   logic [RAW_W-1:0]  raw_pressure;
   logic [RAW_W-1:0]  raw_temp;
   logic signed [24:0] dt_in;
   logic signed [24:0] dt_s1_ff;
   logic [RAW_W-1:0]  d1_s1_ff;

   assign raw_pressure = req_tdata[RAW_W-1:0];
   assign raw_temp     = req_tdata[2*RAW_W-1:RAW_W];
   assign dt_in = $signed({1'b0, raw_temp}) - $signed({1'b0, coef_ref_temp_ff, 8'h00});

   always_ff @(posedge clock) begin
      if (en[1]) begin
         dt_s1_ff <= dt_in;
         d1_s1_ff <= raw_pressure;
      end
   end

   // Stage 2: the three calibration products with dT and the square of dT.
   logic signed [41:0] prod_slope_in;
   logic signed [41:0] prod_offtc_in;
   logic signed [41:0] prod_senstc_in;
   logic signed [49:0] dtsq_in;
   logic signed [41:0] prod_slope_s2_ff;
   logic signed [41:0] prod_offtc_s2_ff;
   logic signed [41:0] prod_senstc_s2_ff;
   logic signed [49:0] dtsq_s2_ff;
   logic [RAW_W-1:0]  d1_s2_ff;

   assign prod_slope_in  = dt_s1_ff * $signed({1'b0, coef_temp_slope_ff});
   assign prod_offtc_in  = dt_s1_ff * $signed({1'b0, coef_offset_tempco_ff});
   assign prod_senstc_in = dt_s1_ff * $signed({1'b0, coef_sens_tempco_ff});
   assign dtsq_in        = dt_s1_ff * dt_s1_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         prod_slope_s2_ff  <= prod_slope_in;
         prod_offtc_s2_ff  <= prod_offtc_in;
         prod_senstc_s2_ff <= prod_senstc_in;
         dtsq_s2_ff        <= dtsq_in;
         d1_s2_ff          <= d1_s1_ff;
      end
   end

   // Stage 3: first-order TEMP, OFF and SENS, T2, and the deviations from
   // 20.00 C and from -15.00 C. Taking the upper bits of a two's complement
   // product is the floor division by the power of two.
   logic signed [18:0] dev_in;
   logic signed [19:0] temp_in;
   logic signed [19:0] devl_in;
   logic               cold_in;
   logic               frigid_in;
   logic [35:0]        off_in;
   logic [34:0]        sens_in;
   logic [16:0]        t2_in;
   logic signed [18:0] dev_s3_ff;
   logic signed [19:0] devl_s3_ff;
   logic signed [19:0] temp_s3_ff;
   logic               cold_s3_ff;
   logic               frigid_s3_ff;
   logic [35:0]        off_s3_ff;
   logic [34:0]        sens_s3_ff;
   logic [16:0]        t2_s3_ff;
   logic [RAW_W-1:0]   d1_s3_ff;

   assign dev_in    = prod_slope_s2_ff[41:23];
   assign temp_in   = {dev_in[18], dev_in} + 20'(TEMP_REF_CENTI);
   assign devl_in   = {dev_in[18], dev_in} + 20'(TEMP_REF_CENTI + TEMP_LOW_CENTI);
   assign cold_in   = dev_in[18];
   assign frigid_in = dev_in < -19'sd3500;
   assign off_in    = {4'h0, coef_offset_ff, 16'h0000}
                    + {prod_offtc_s2_ff[41], prod_offtc_s2_ff[41:7]};
   assign sens_in   = {4'h0, coef_sens_ff, 15'h0000}
                    + {prod_senstc_s2_ff[41], prod_senstc_s2_ff[41:8]};
   // dT squared is never negative and stays below 2^48.
   assign t2_in     = dtsq_s2_ff[47:31];

   always_ff @(posedge clock) begin
      if (en[3]) begin
         dev_s3_ff    <= dev_in;
         devl_s3_ff   <= devl_in;
         temp_s3_ff   <= temp_in;
         cold_s3_ff   <= cold_in;
         frigid_s3_ff <= frigid_in;
         off_s3_ff    <= off_in;
         sens_s3_ff   <= sens_in;
         t2_s3_ff     <= t2_in;
         d1_s3_ff     <= d1_s2_ff;
      end
   end

   // Stage 4: the squared deviations and the final temperature. The square
   // below -15.00 C is only used there, where it is smaller than the other.
   logic signed [37:0] devsq_full;
   logic signed [39:0] devlsq_full;
   logic [34:0]        devsq_in;
   logic [34:0]        devlsq_in;
   logic [19:0]        tfin_in;
   logic [34:0]        devsq_s4_ff;
   logic [34:0]        devlsq_s4_ff;
   logic [19:0]        tfin_s4_ff;
   logic               cold_s4_ff;
   logic               frigid_s4_ff;
   logic [35:0]        off_s4_ff;
   logic [34:0]        sens_s4_ff;
   logic [RAW_W-1:0]   d1_s4_ff;

   assign devsq_full  = dev_s3_ff * dev_s3_ff;
   assign devlsq_full = devl_s3_ff * devl_s3_ff;
   assign devsq_in    = devsq_full[34:0];
   assign devlsq_in   = devlsq_full[34:0];
   assign tfin_in     = cold_s3_ff ? (temp_s3_ff - {3'b000, t2_s3_ff}) : temp_s3_ff;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         devsq_s4_ff  <= devsq_in;
         devlsq_s4_ff <= devlsq_in;
         tfin_s4_ff   <= tfin_in;
         cold_s4_ff   <= cold_s3_ff;
         frigid_s4_ff <= frigid_s3_ff;
         off_s4_ff    <= off_s3_ff;
         sens_s4_ff   <= sens_s3_ff;
         d1_s4_ff     <= d1_s3_ff;
      end
   end

   // Stage 5: OFF2 and SENS2 from shifts and adds, then the corrected OFF
   // and SENS. Both corrections are non-negative, so the shifts are floors.
   logic [39:0] five_sq;
   logic [39:0] seven_sql;
   logic [39:0] eleven_sql;
   logic [39:0] off2;
   logic [39:0] sens2;
   logic [40:0] offf_in;
   logic [39:0] sensf_in;
   logic [40:0] offf_s5_ff;
   logic [39:0] sensf_s5_ff;
   logic [19:0] tfin_s5_ff;
   logic [RAW_W-1:0] d1_s5_ff;

   assign five_sq    = {3'b000, devsq_s4_ff, 2'b00} + {5'b00000, devsq_s4_ff};
   assign seven_sql  = {2'b00, devlsq_s4_ff, 3'b000} - {5'b00000, devlsq_s4_ff};
   assign eleven_sql = {2'b00, devlsq_s4_ff, 3'b000} + {4'h0, devlsq_s4_ff, 1'b0}
                     + {5'b00000, devlsq_s4_ff};
   assign off2  = (cold_s4_ff ? {1'b0, five_sq[39:1]} : 40'd0)
                + (frigid_s4_ff ? seven_sql : 40'd0);
   assign sens2 = (cold_s4_ff ? {2'b00, five_sq[39:2]} : 40'd0)
                + (frigid_s4_ff ? {1'b0, eleven_sql[39:1]} : 40'd0);
   assign offf_in  = {{5{off_s4_ff[35]}}, off_s4_ff} - {1'b0, off2};
   assign sensf_in = {{5{sens_s4_ff[34]}}, sens_s4_ff} - sens2;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         offf_s5_ff  <= offf_in;
         sensf_s5_ff <= sensf_in;
         tfin_s5_ff  <= tfin_s4_ff;
         d1_s5_ff    <= d1_s4_ff;
      end
   end

   // Stage 6: D1 times the corrected SENS as two partial products, one on
   // the low 20 bits (unsigned) and one on the high 20 bits (signed).
   logic [43:0]        pp_lo_in;
   logic signed [44:0] pp_hi_in;
   logic [43:0]        pp_lo_s6_ff;
   logic signed [44:0] pp_hi_s6_ff;
   logic [40:0]        offf_s6_ff;
   logic [19:0]        tfin_s6_ff;

   assign pp_lo_in = d1_s5_ff * sensf_s5_ff[19:0];
   assign pp_hi_in = $signed({1'b0, d1_s5_ff}) * $signed(sensf_s5_ff[39:20]);

   always_ff @(posedge clock) begin
      if (en[6]) begin
         pp_lo_s6_ff <= pp_lo_in;
         pp_hi_s6_ff <= pp_hi_in;
         offf_s6_ff  <= offf_s5_ff;
         tfin_s6_ff  <= tfin_s5_ff;
      end
   end

   // Stage 7: the full product, which stays within 64 signed bits.
   logic [63:0] prod_in;
   logic [63:0] prod_s7_ff;
   logic [40:0] offf_s7_ff;
   logic [19:0] tfin_s7_ff;

   assign prod_in = {pp_hi_s6_ff[43:0], 20'h00000} + {20'h00000, pp_lo_s6_ff};

   always_ff @(posedge clock) begin
      if (en[7]) begin
         prod_s7_ff <= prod_in;
         offf_s7_ff <= offf_s6_ff;
         tfin_s7_ff <= tfin_s6_ff;
      end
   end

   // Stage 8: P = floor((floor(D1 * SENS / 2^21) - OFF) / 2^15). The product
   // and OFF are bounded so tightly that P always fits in 29 signed bits,
   // hence the 32-bit saturation never bites and sign extension is exact.
   logic [43:0]        pdiff;
   logic [PRES_W-1:0]  pres_in;
   logic [PRES_W-1:0]  pres_ff;
   logic [TEMP_W-1:0]  temp_ff;

   assign pdiff   = {prod_s7_ff[63], prod_s7_ff[63:21]} - {{3{offf_s7_ff[40]}}, offf_s7_ff};
   assign pres_in = {{3{pdiff[43]}}, pdiff[43:15]};

   always_ff @(posedge clock) begin
      if (en[8]) begin
         pres_ff <= pres_in;
         temp_ff <= tfin_s7_ff[TEMP_W-1:0];
      end
   end

   assign rsp_tdata = {(RSP_TDATA_W - TEMP_W - PRES_W)'(0), pres_ff, temp_ff};

endmodule

[src/baro_checker.sv]
// Port-level checker for the compensation block and its bind statement.
`timescale 1ns / 1ps

module baro_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [baro_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import baro_pkg::*;

   // A held response keeps its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // With the response side open or empty, the pipeline never refuses a
   // request.
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tready || !rsp_tvalid) |-> req_tready)
      else $error("request refused with free pipeline");

   // The pad bits above the pressure field are zero.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_TDATA_W-1:TEMP_W+PRES_W] == '0)
      else $error("response pad bits not zero");

endmodule

bind baro_pressure_temp_compensation baro_checker u_baro_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[test/baro_compensation_checker.sv]
// Checker that predicts and compares every compensated reading of the block.
`timescale 1ns / 1ps

module baro_compensation_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // req_tdata: raw_pressure [23:0], raw_temp [47:24].
   input  logic [baro_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // rsp_tdata: temp_centi [18:0], pressure_pa [50:19], zeros above.
   input  logic [baro_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_wen,
   input  logic [baro_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [baro_pkg::COEF_W-1:0]      csr_wdata,
   output int                               fail_count,
   output int                               pending_count
);
   import baro_pkg::*;

   // Wide enough that no intermediate product can overflow.
   typedef logic signed [95:0] wide_type;

   localparam int REF_SHIFT       = 8;
   localparam int SLOPE_SHIFT     = 23;
   localparam int OFF_BASE_SHIFT  = 16;
   localparam int OFF_TC_SHIFT    = 7;
   localparam int SENS_BASE_SHIFT = 15;
   localparam int SENS_TC_SHIFT   = 8;
   localparam int T2_SHIFT        = 31;
   localparam int PROD_SHIFT      = 21;
   localparam int PRES_SHIFT      = 15;
   localparam wide_type PRES_MAX  = 96'sh7FFF_FFFF;
   localparam wide_type PRES_MIN  = -96'sh8000_0000;

   typedef struct packed {
      logic [TEMP_W-1:0] temp_centi;
      logic [PRES_W-1:0] pressure_pa;
   } reading_type;

   logic [COEF_W-1:0] cal_sens, cal_offset, cal_sens_tc;
   logic [COEF_W-1:0] cal_offset_tc, cal_ref_temp, cal_temp_slope;
   reading_type       expected_readings[$];

   function automatic reading_type compensate(input logic [RAW_W-1:0] raw_pressure,
                                              input logic [RAW_W-1:0] raw_temp);
      wide_type d1, d2, c1, c2, c3, c4, c5, c6;
      wide_type dt, temp, off, sens, t2, off2, sens2, dev, pres;
      reading_type r;
      d1 = wide_type'(raw_pressure);
      d2 = wide_type'(raw_temp);
      c1 = wide_type'(cal_sens);
      c2 = wide_type'(cal_offset);
      c3 = wide_type'(cal_sens_tc);
      c4 = wide_type'(cal_offset_tc);
      c5 = wide_type'(cal_ref_temp);
      c6 = wide_type'(cal_temp_slope);

      // Arithmetic shifts of signed values round toward minus infinity.
      dt   = d2 - (c5 <<< REF_SHIFT);
      temp = TEMP_REF_CENTI + ((dt * c6) >>> SLOPE_SHIFT);
      off  = (c2 <<< OFF_BASE_SHIFT) + ((c4 * dt) >>> OFF_TC_SHIFT);
      sens = (c1 <<< SENS_BASE_SHIFT) + ((c3 * dt) >>> SENS_TC_SHIFT);

      t2 = '0;
      off2 = '0;
      sens2 = '0;
      if (temp < TEMP_REF_CENTI) begin
         dev   = temp - TEMP_REF_CENTI;
         t2    = (dt * dt) >>> T2_SHIFT;
         off2  = (5 * dev * dev) >>> 1;
         sens2 = (5 * dev * dev) >>> 2;
         if (temp < -TEMP_LOW_CENTI) begin
            dev   = temp + TEMP_LOW_CENTI;
            off2  = off2 + 7 * dev * dev;
            sens2 = sens2 + ((11 * dev * dev) >>> 1);
         end
      end
      temp = temp - t2;
      off  = off - off2;
      sens = sens - sens2;

      pres = (((d1 * sens) >>> PROD_SHIFT) - off) >>> PRES_SHIFT;
      if (pres > PRES_MAX)
         pres = PRES_MAX;
      if (pres < PRES_MIN)
         pres = PRES_MIN;

      r.temp_centi  = temp[TEMP_W-1:0];
      r.pressure_pa = pres[PRES_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      reading_type got, want;
      if (reset) begin
         cal_sens       = '0;
         cal_offset     = '0;
         cal_sens_tc    = '0;
         cal_offset_tc  = '0;
         cal_ref_temp   = '0;
         cal_temp_slope = '0;
         expected_readings.delete();
      end else begin
         if (csr_wen) begin
            unique case (csr_addr)
               CSR_COEF_SENS:          cal_sens       = csr_wdata;
               CSR_COEF_OFFSET:        cal_offset     = csr_wdata;
               CSR_COEF_SENS_TEMPCO:   cal_sens_tc    = csr_wdata;
               CSR_COEF_OFFSET_TEMPCO: cal_offset_tc  = csr_wdata;
               CSR_COEF_REF_TEMP:      cal_ref_temp   = csr_wdata;
               CSR_COEF_TEMP_SLOPE:    cal_temp_slope = csr_wdata;
               default: ;  // Unused indexes change nothing.
            endcase
         end

         if (req_tvalid && req_tready)
            expected_readings.push_back(compensate(req_tdata[RAW_W-1:0],
                                                   req_tdata[2*RAW_W-1:RAW_W]));

         if (rsp_tvalid && rsp_tready) begin
            if (expected_readings.size() == 0) begin
               report_mismatch($sformatf("response 0x%h with no request outstanding",
                                         rsp_tdata));
            end else begin
               want = expected_readings.pop_front();
               got.temp_centi  = rsp_tdata[TEMP_W-1:0];
               got.pressure_pa = rsp_tdata[TEMP_W +: PRES_W];
               if (got.temp_centi !== want.temp_centi)
                  report_mismatch($sformatf("temp_centi %0d, expected %0d",
                                            $signed(got.temp_centi),
                                            $signed(want.temp_centi)));
               if (got.pressure_pa !== want.pressure_pa)
                  report_mismatch($sformatf("pressure_pa %0d, expected %0d",
                                            $signed(got.pressure_pa),
                                            $signed(want.pressure_pa)));
               if (rsp_tdata[RSP_TDATA_W-1:TEMP_W+PRES_W] !== '0)
                  report_mismatch($sformatf("padding bits 0x%h not zero",
                                            rsp_tdata[RSP_TDATA_W-1:TEMP_W+PRES_W]));
            end
         end
      end
      pending_count <= expected_readings.size();
   end

endmodule

[test/testbench.sv]
// Top of the testbench: clock, reset, request and csr stimulus, and the verdict.
`timescale 1ns / 1ps

module testbench;
   import baro_pkg::*;

   localparam int CLK_HALF         = 4;
   localparam int RESET_CYCLES     = 12;
   localparam int RANDOM_PHASES    = 6;
   localparam int PHASE_READINGS   = 150;
   // The long response stall starts once this many responses have arrived,
   // which falls in the middle of a random phase.
   localparam int LONG_HOLD_AFTER  = 400;
   localparam int LONG_HOLD_CYCLES = 200;
   // The longest legitimate stretch without any transfer comes from the long
   // stall; the limit leaves a wide margin over that.
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int DRAIN_CYCLES     = NUM_STAGES + 8;

   localparam logic [RAW_W-1:0] RAW_MAX = '1;

   // Register indexes that the block does not implement.
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [COEF_W-1:0] sens, offset, sens_tc, offset_tc, ref_temp, temp_slope;
   } cal_words_type;

   // A realistic factory calibration. Its reference point C5 * 2^8 is
   // 8566784, so a raw temperature of exactly that gives 20.00 C.
   localparam cal_words_type TYPICAL_CAL = '{sens: 16'd40127, offset: 16'd36924,
                                             sens_tc: 16'd23317, offset_tc: 16'd23282,
                                             ref_temp: 16'd33464, temp_slope: 16'd28312};
   localparam cal_words_type MAX_CAL     = '{default: '1};
   localparam cal_words_type ZERO_CAL    = '{default: '0};
   // Zero reference and the steepest slope: every raw temperature reads 20.00 C or warmer.
   localparam cal_words_type HOT_CAL     = '{sens: '0, offset: '0, sens_tc: '1,
                                             offset_tc: '1, ref_temp: '0, temp_slope: '1};

   typedef enum {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_RARELY, RDY_PERIODIC} ready_mode_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // req_tdata: raw_pressure [23:0], raw_temp [47:24].
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // rsp_tdata: temp_centi [18:0], pressure_pa [50:19], zeros above.
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wen    = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [COEF_W-1:0]      csr_wdata  = '0;

   int            fail_count;
   int            pending_count;
   int            responses_seen = 0;
   // Calibration last written, used only to aim the random temperatures.
   cal_words_type active_cal     = '0;

   always #(CLK_HALF) clock = ~clock;

   baro_pressure_temp_compensation DUT (.*);

   baro_compensation_checker result_check (.*);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         responses_seen <= responses_seen + 1;
   end

   // One register write per clock; the caller lowers the write enable after
   // the last one so that it is never dropped and raised in the same step.
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] index,
                            input logic [COEF_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Loads a full calibration set. Random data also goes to the two unused
   // indexes, in between the real ones, to show that those writes are dropped.
   task automatic load_cal(input cal_words_type cal);
      write_csr(CSR_COEF_SENS, cal.sens);
      write_csr(CSR_COEF_OFFSET, cal.offset);
      write_csr(CSR_SPARE_LO, COEF_W'($urandom));
      write_csr(CSR_COEF_SENS_TEMPCO, cal.sens_tc);
      write_csr(CSR_COEF_OFFSET_TEMPCO, cal.offset_tc);
      write_csr(CSR_COEF_REF_TEMP, cal.ref_temp);
      write_csr(CSR_SPARE_HI, COEF_W'($urandom));
      write_csr(CSR_COEF_TEMP_SLOPE, cal.temp_slope);
      csr_wen <= 1'b0;
      active_cal = cal;
   endtask

   // Offers one request and returns at the clock edge that accepts it, with
   // the valid still high so that a following request can go back to back.
   task automatic send_reading(input logic [RAW_W-1:0] raw_pressure,
                               input logic [RAW_W-1:0] raw_temp);
      req_tvalid <= 1'b1;
      req_tdata  <= {raw_temp, raw_pressure};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops offering requests until every expected response has come back.
   // The checker's count takes in a request only after the edge that
   // accepts it, so the first look comes at the following edge.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Half of the raw temperatures sit around the calibrated reference point,
   // at distances up to 2^k counts for a random k from 0 to 22, so that the
   // temperature bands and their borders are hit where the calibration allows.
   // The rest spread over the whole range, with the two extremes now and then.
   function automatic logic [REQ_TDATA_W-1:0] random_reading();
      int shape, center, span, temp_raw;
      logic [RAW_W-1:0] raw_pressure, raw_temp;
      shape = $urandom_range(0, 9);
      if (shape < 5) begin
         center   = int'(active_cal.ref_temp) << 8;
         span     = 1 << $urandom_range(0, RAW_W - 2);
         temp_raw = center + int'($urandom_range(0, 2 * span)) - span;
         if (temp_raw < 0)
            temp_raw = 0;
         if (temp_raw > int'(RAW_MAX))
            temp_raw = int'(RAW_MAX);
         raw_temp = temp_raw[RAW_W-1:0];
      end else if (shape < 9) begin
         raw_temp = RAW_W'($urandom_range(0, RAW_MAX));
      end else begin
         raw_temp = $urandom_range(0, 1) ? RAW_MAX : '0;
      end
      if ($urandom_range(0, 7) == 0)
         raw_pressure = $urandom_range(0, 1) ? RAW_MAX : '0;
      else
         raw_pressure = RAW_W'($urandom_range(0, RAW_MAX));
      return {raw_temp, raw_pressure};
   endfunction

   // Sends requests in bursts of random length. A third of the bursts follow
   // each other without a gap, the others are separated by short idle gaps
   // with junk on the data lines. Now and then the sender waits for the
   // pipeline to empty completely before the next burst.
   task automatic run_random(input int count);
      int sent, burst, gap;
      logic [REQ_TDATA_W-1:0] reading;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 19) == 0)
            wait_drained();
         burst = $urandom_range(1, 32);
         while (burst > 0 && sent < count) begin
            reading = random_reading();
            send_reading(reading[RAW_W-1:0], reading[REQ_TDATA_W-1:RAW_W]);
            sent++;
            burst--;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            req_tdata  <= REQ_TDATA_W'({$urandom, $urandom});
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Calibration for each random phase: realistic, both extremes, fully
   // random, and a deep-cold setting with the highest reference and slope.
   function automatic cal_words_type phase_cal(input int phase);
      cal_words_type cal;
      cal = '{sens: COEF_W'($urandom_range(0, 16'hFFFF)),
              offset: COEF_W'($urandom_range(0, 16'hFFFF)),
              sens_tc: COEF_W'($urandom_range(0, 16'hFFFF)),
              offset_tc: COEF_W'($urandom_range(0, 16'hFFFF)),
              ref_temp: COEF_W'($urandom_range(0, 16'hFFFF)),
              temp_slope: COEF_W'($urandom_range(0, 16'hFFFF))};
      unique case (phase)
         0: cal = TYPICAL_CAL;
         1: cal = MAX_CAL;
         2: cal = ZERO_CAL;
         4: begin
            cal.ref_temp   = '1;
            cal.temp_slope = '1;
         end
         default: ;
      endcase
      return cal;
   endfunction

   // The response side mostly switches between stall patterns of its own,
   // each held for a random stretch. Once, in the middle of the random
   // stimulus, it stops taking responses for a long count of cycles while
   // the sender keeps offering requests, so the pipeline fills and the
   // block has to hold off its request side.
   initial begin : receiver
      ready_mode_type mode;
      int left, tick;
      bit long_hold_done;
      mode = RDY_ALWAYS;
      left = 0;
      tick = 0;
      long_hold_done = 1'b0;
      forever begin
         if (!long_hold_done && responses_seen >= LONG_HOLD_AFTER && req_tvalid) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end else begin
            if (left == 0) begin
               mode = ready_mode_type'($urandom_range(0, 4));
               left = $urandom_range(20, 120);
            end
            left--;
            tick++;
            unique case (mode)
               RDY_ALWAYS: rsp_tready <= 1'b1;
               RDY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               RDY_MOSTLY: rsp_tready <= ($urandom_range(0, 7) != 0);
               RDY_RARELY: rsp_tready <= ($urandom_range(0, 7) == 0);
               default:    rsp_tready <= (tick % 5) < 3;
            endcase
            @(posedge clock);
         end
      end
   end

   // Ends the run if nothing at all moves for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("testbench failed");
      $finish;
   end

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // All calibration words are still at their reset value of zero.
      send_reading('0, '0);
      send_reading(RAW_MAX, RAW_MAX);
      wait_drained();

      // Realistic calibration: a room-temperature sample, every corner of
      // the two raw fields, and the borders of the temperature bands.
      load_cal(TYPICAL_CAL);
      send_reading(24'd9085466, 24'd8569150);
      send_reading('0, '0);
      send_reading(RAW_MAX, '0);
      send_reading('0, RAW_MAX);
      send_reading(RAW_MAX, RAW_MAX);
      // Exactly 20.00 C: no second-order correction.
      send_reading(24'd9085466, 24'd8566784);
      // One count colder gives 19.99 C and switches the correction on.
      send_reading(24'd9085466, 24'd8566783);
      // First-order temperature of exactly -15.00 C, then -15.01 C where the extra cold term starts.
      send_reading(24'd9085466, 24'd7529764);
      send_reading(24'd9085466, 24'd7529763);
      wait_drained();

      // Every word at its maximum: the coldest reachable temperatures.
      load_cal(MAX_CAL);
      send_reading(RAW_MAX, RAW_MAX);
      send_reading('0, '0);
      send_reading(RAW_MAX, '0);
      wait_drained();

      // The hottest reachable temperatures.
      load_cal(HOT_CAL);
      send_reading(RAW_MAX, RAW_MAX);
      send_reading(RAW_MAX, '0);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_cal(phase_cal(phase));
         run_random(PHASE_READINGS);
         wait_drained();
      end

      // Give a stray extra response time to show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

[baro_pressure_temp_compensation.f]
src/baro_pkg.sv
src/baro_pressure_temp_compensation.sv
src/baro_checker.sv
test/baro_compensation_checker.sv
test/testbench.sv
